FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with a bare-name include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked same-cycle implication, built on the macro above.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/stt_pkg.sv
// Package for the source text tokenizer: token kinds, character codes,
// result entry type and the keyword lookup. No dependencies.
package stt_pkg;

	// Token kinds, in enumeration order.
	localparam logic [4:0] K_ADD     = 5'd0;
	localparam logic [4:0] K_SUB     = 5'd1;
	localparam logic [4:0] K_MUL     = 5'd2;
	localparam logic [4:0] K_DIV     = 5'd3;
	localparam logic [4:0] K_ASSIGN  = 5'd4;
	localparam logic [4:0] K_SEMI    = 5'd5;
	localparam logic [4:0] K_LPAREN  = 5'd6;
	localparam logic [4:0] K_RPAREN  = 5'd7;
	localparam logic [4:0] K_LBRACE  = 5'd8;
	localparam logic [4:0] K_RBRACE  = 5'd9;
	localparam logic [4:0] K_ID      = 5'd10;
	localparam logic [4:0] K_PRINT   = 5'd11;
	localparam logic [4:0] K_IF      = 5'd12;
	localparam logic [4:0] K_WHILE   = 5'd13;
	localparam logic [4:0] K_FOR     = 5'd14;
	localparam logic [4:0] K_INT     = 5'd15;
	localparam logic [4:0] K_DOUBLE  = 5'd16;
	localparam logic [4:0] K_STRING  = 5'd17;
	localparam logic [4:0] K_MAGIC   = 5'd18;
	localparam logic [4:0] K_UNKNOWN = 5'd19;
	localparam logic [4:0] K_ELSE    = 5'd20;
	localparam logic [4:0] K_QUOTE   = 5'd21;
	localparam logic [4:0] K_LTHEN   = 5'd22;
	localparam logic [4:0] K_GTHEN   = 5'd23;
	localparam logic [4:0] K_TEXT    = 5'd24;
	localparam logic [4:0] K_EQ      = 5'd25;
	localparam logic [4:0] K_NEQ     = 5'd26;
	localparam logic [4:0] K_LTE     = 5'd27;
	localparam logic [4:0] K_GTE     = 5'd28;
	localparam logic [4:0] K_COMMA   = 5'd29;
	localparam logic [4:0] KIND_MAX  = K_COMMA;

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// Output field widths and limits.
	localparam int KIND_W  = 5;
	localparam int LINE_W  = 16;
	localparam int START_W = 24;
	localparam int LEN_W   = 16;
	localparam int TDATA_W = 64;
	localparam logic [LEN_W-1:0]  LEN_MAX      = '1;
	localparam logic [LINE_W-1:0] LINE_OUT_MAX = '1;

	// Keyword spellings, first character in the high byte.
	localparam logic [39:0] KW_PRINT  = 40'h7072696E74;
	localparam logic [39:0] KW_ETE    = 40'h0000657465;
	localparam logic [39:0] KW_KAM    = 40'h00006B616D;
	localparam logic [39:0] KW_WHILE  = 40'h7768696C65;
	localparam logic [39:0] KW_FOR    = 40'h0000666F72;
	localparam logic [39:0] KW_TIV    = 40'h0000746976;
	localparam logic [39:0] KW_SAHOX  = 40'h7361686F78;
	localparam logic [39:0] KW_TOX    = 40'h0000746F78;

	// Output FIFO geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic              last;
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
		logic [LINE_W-1:0]  line;
		logic [KIND_W-1:0]  kind;
	} result_t;

	// Identifier of known length whose captured bytes are in word.
	function automatic logic [4:0] keyword_kind(input logic [39:0] word,
			input logic [3:0] len);
		logic [4:0] k;
		k = K_ID;
		if (len == 4'd5) begin
			if (word == KW_PRINT) k = K_PRINT;
			if (word == KW_WHILE) k = K_WHILE;
			if (word == KW_SAHOX) k = K_DOUBLE;
		end
		if (len == 4'd3) begin
			if (word == KW_ETE) k = K_IF;
			if (word == KW_KAM) k = K_ELSE;
			if (word == KW_FOR) k = K_FOR;
			if (word == KW_TIV) k = K_INT;
			if (word == KW_TOX) k = K_STRING;
		end
		return k;
	endfunction

endpackage

FILE: rtl/core/source_text_tokenizer.sv
// Source text tokenizer top level: byte input register, scan state and
// token FIFO. Depends on stt_pkg.
//
// Usage:
//   s_* channel carries one source byte per transfer; byte 0 ends the text,
//   flushes the open token and returns the scanner to its reset state.
//   m_* channel carries one token per transfer: kind, line, start offset and
//   length in m_tdata, and m_tlast on the last token caused by a byte.
// A token that a byte causes goes through the input register, then the scan
//   step writes it into the FIFO, from which it is offered on m_*.
// Throughput: one byte per cycle while each byte gives at most one token and
//   the FIFO has room; a byte that gives two tokens sends both over the single
//   m_* port, so the sustained rate is set by the tokens per byte on that port.
// The input register and a four-entry token FIFO part the two sides: a
//   byte is scanned only while the FIFO has room for two tokens, so a
//   stalled receiver backs pressure up to s_tready without losing tokens.
// Reset (arst_n low) clears the scan state, line and offset counters,
//   the input register's valid bit and the FIFO pointers and count.
module source_text_tokenizer
	import stt_pkg::*;
#(
	parameter int KEYWORD_CHARS = 5,
	parameter int OFFSET_BITS   = 24,
	parameter int LINE_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] text_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [4:0] token_kind, [20:5] line_number,
	                                      // [44:21] token_start, [60:45] token_length,
	                                      // [63:61] zero
	output logic               m_tlast    // last_of_run
);

	localparam int KW_BITS = 8 * KEYWORD_CHARS;
	localparam int LX_W = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
	localparam int OX_W = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;

	// Scan modes.
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_SYMBOL = 3'd1;
	localparam logic [2:0] MODE_IDENT  = 3'd2;
	localparam logic [2:0] MODE_NUMBER = 3'd3;
	localparam logic [2:0] MODE_STRING = 3'd4;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Scan state.
	logic [2:0]             mode_q, mode_n;
	logic [7:0]             pend_q, pend_n;
	logic [OFFSET_BITS-1:0] begin_q, begin_n;
	logic [LEN_W-1:0]       run_q, run_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [KW_BITS-1:0]     cap_q, cap_n;

	// Token FIFO.
	result_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	logic fire;
	logic pop;

	// Flush of the open token and the token of the current byte.
	logic             a_v, b_v, go_idle;
	logic             flush_v;
	logic [4:0]       flush_kind, b_kind;
	logic [OFFSET_BITS-1:0] flush_start, b_start;
	logic [LEN_W-1:0] flush_len, b_len;
	logic [LEN_W-1:0] run_grow;
	logic [4:0]       ident_kind, single_kind, double_kind;
	logic             is_digit, is_alpha;
	logic [LINE_W-1:0] line_out;
	logic [LX_W-1:0]   line_ext;
	result_t          res_a, res_b, res0, res1;
	logic [1:0]       push_n;

	function automatic logic [START_W-1:0] start_field(input logic [OFFSET_BITS-1:0] v);
		logic [OX_W-1:0] ext;
		ext = OX_W'(v);
		return ext[START_W-1:0];
	endfunction

	// Scan a byte only while the FIFO can take two tokens.
	assign fire     = valid_s1 && (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || fire;
	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	assign is_digit = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign is_alpha = ((byte_s1 >= CH_UC_A) && (byte_s1 <= CH_UC_Z)) ||
	                  ((byte_s1 >= CH_LC_A) && (byte_s1 <= CH_LC_Z)) ||
	                  (byte_s1 == CH_UNDER);
	assign run_grow = (run_q == LEN_MAX) ? LEN_MAX : run_q + 1'b1;

	// Keyword match needs an exact length and nothing above the low five bytes.
	always_comb begin
		ident_kind = K_ID;
		if ((run_q <= LEN_W'(KEYWORD_CHARS)) && ((cap_q >> 40) == '0)) begin
			ident_kind = keyword_kind(cap_q[39:0], run_q[3:0]);
		end
	end

	always_comb begin
		case (pend_q)
			CH_EQ:   single_kind = K_ASSIGN;
			CH_LT:   single_kind = K_LTHEN;
			CH_GT:   single_kind = K_GTHEN;
			default: single_kind = K_UNKNOWN;
		endcase
		case (pend_q)
			CH_EQ:   double_kind = K_EQ;
			CH_BANG: double_kind = K_NEQ;
			CH_LT:   double_kind = K_LTE;
			default: double_kind = K_GTE;
		endcase
	end

	// What the open token emits if it ends here.
	always_comb begin
		flush_v     = 1'b0;
		flush_kind  = K_ID;
		flush_start = begin_q;
		flush_len   = run_q;
		unique case (mode_q)
			MODE_SYMBOL: begin
				flush_v    = 1'b1;
				flush_kind = single_kind;
				flush_len  = LEN_W'(1);
			end
			MODE_IDENT: begin
				flush_v    = 1'b1;
				flush_kind = ident_kind;
			end
			MODE_NUMBER: begin
				flush_v    = 1'b1;
				flush_kind = K_MAGIC;
			end
			MODE_STRING: begin
				flush_v    = (run_q != '0);
				flush_kind = K_TEXT;
			end
			default: ;
		endcase
	end

	// One scan step on the registered byte.
	always_comb begin
		mode_n  = mode_q;
		pend_n  = pend_q;
		begin_n = begin_q;
		run_n   = run_q;
		line_n  = line_q;
		pos_n   = pos_q;
		cap_n   = cap_q;
		a_v     = 1'b0;
		b_v     = 1'b0;
		b_kind  = K_UNKNOWN;
		b_start = pos_q;
		b_len   = LEN_W'(1);
		go_idle = 1'b0;

		if (byte_s1 == CH_NUL) begin
			// End of text: flush, then back to the reset state.
			a_v     = flush_v;
			mode_n  = MODE_IDLE;
			pend_n  = '0;
			begin_n = '0;
			run_n   = '0;
			line_n  = '0;
			pos_n   = '0;
			cap_n   = '0;
		end else begin
			pos_n = pos_q + 1'b1;
			unique case (mode_q)
				MODE_STRING: begin
					if (byte_s1 == CH_QUOTE) begin
						a_v    = flush_v;
						b_v    = 1'b1;
						b_kind = K_QUOTE;
						mode_n = MODE_IDLE;
					end else begin
						run_n = run_grow;
					end
				end
				MODE_SYMBOL: begin
					if (byte_s1 == CH_EQ) begin
						b_v     = 1'b1;
						b_kind  = double_kind;
						b_start = begin_q;
						b_len   = LEN_W'(2);
						mode_n  = MODE_IDLE;
					end else begin
						a_v     = flush_v;
						go_idle = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_alpha || is_digit) begin
						if (run_q < LEN_W'(KEYWORD_CHARS)) begin
							cap_n = {cap_q[KW_BITS-9:0], byte_s1};
						end
						run_n = run_grow;
					end else begin
						a_v     = flush_v;
						go_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						run_n = run_grow;
					end else begin
						a_v     = flush_v;
						go_idle = 1'b1;
					end
				end
				default: go_idle = 1'b1;
			endcase

			if (go_idle) begin
				mode_n = MODE_IDLE;
				case (byte_s1) inside
					CH_SPACE, CH_TAB, CH_CR: ;
					CH_LF: begin
						if (line_q != '1) begin
							line_n = line_q + 1'b1;
						end
					end
					CH_EQ, CH_BANG, CH_LT, CH_GT: begin
						mode_n  = MODE_SYMBOL;
						pend_n  = byte_s1;
						begin_n = pos_q;
					end
					CH_COMMA:  begin b_v = 1'b1; b_kind = K_COMMA;  end
					CH_SEMI:   begin b_v = 1'b1; b_kind = K_SEMI;   end
					CH_LPAREN: begin b_v = 1'b1; b_kind = K_LPAREN; end
					CH_RPAREN: begin b_v = 1'b1; b_kind = K_RPAREN; end
					CH_LBRACE: begin b_v = 1'b1; b_kind = K_LBRACE; end
					CH_RBRACE: begin b_v = 1'b1; b_kind = K_RBRACE; end
					CH_DOLLAR: begin b_v = 1'b1; b_kind = K_ADD;    end
					CH_TILDE:  begin b_v = 1'b1; b_kind = K_SUB;    end
					CH_HASH:   begin b_v = 1'b1; b_kind = K_MUL;    end
					CH_AT:     begin b_v = 1'b1; b_kind = K_DIV;    end
					CH_QUOTE: begin
						// Opening quote; content starts at the next byte.
						b_v     = 1'b1;
						b_kind  = K_QUOTE;
						mode_n  = MODE_STRING;
						run_n   = '0;
						begin_n = pos_q + 1'b1;
					end
					[CH_0:CH_9]: begin
						mode_n  = MODE_NUMBER;
						begin_n = pos_q;
						run_n   = LEN_W'(1);
					end
					[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z], CH_UNDER: begin
						mode_n  = MODE_IDENT;
						begin_n = pos_q;
						run_n   = LEN_W'(1);
						cap_n   = KW_BITS'(byte_s1);
					end
					default: begin
						b_v    = 1'b1;
						b_kind = K_UNKNOWN;
					end
				endcase
			end
		end
	end

	// Every token of this byte reports the line before any newline in it.
	assign line_ext = LX_W'(line_q);
	assign line_out = (line_ext > LX_W'(LINE_OUT_MAX)) ? LINE_OUT_MAX : line_ext[LINE_W-1:0];

	always_comb begin
		res_a.kind  = flush_kind;
		res_a.line  = line_out;
		res_a.start = start_field(flush_start);
		res_a.len   = flush_len;
		res_a.last  = !b_v;
		res_b.kind  = b_kind;
		res_b.line  = line_out;
		res_b.start = start_field(b_start);
		res_b.len   = b_len;
		res_b.last  = 1'b1;
		res0        = a_v ? res_a : res_b;
		res1        = res_b;
		push_n      = {1'b0, a_v} + {1'b0, b_v};
	end

	// Commit the scan step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= '0;
			begin_q <= '0;
			run_q   <= '0;
			line_q  <= '0;
			pos_q   <= '0;
			cap_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			pend_q  <= pend_n;
			begin_q <= begin_n;
			run_q   <= run_n;
			line_q  <= line_n;
			pos_q   <= pos_n;
			cap_q   <= cap_n;
		end
	end

	// FIFO storage: up to two writes per step, in token order.
	always_ff @(posedge clk) begin
		if (fire && (push_n != 2'd0)) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (fire && (push_n == 2'd2)) begin
			fifo_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW + 1)'(fire ? push_n : 2'd0)
			           - (FIFO_AW + 1)'(pop);
		end
	end

	always_comb begin
		result_t head;
		head    = fifo_q[rd_ptr_q];
		m_tdata = {{(TDATA_W - KIND_W - LINE_W - START_W - LEN_W){1'b0}},
		           head.len, head.start, head.line, head.kind};
		m_tlast = head.last;
	end

endmodule

FILE: rtl/core/stt_checker.sv
// Port-level checker for the source text tokenizer, bound to the top level.
// Depends on stt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stt_checker
	import stt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	// A stalled token transfer holds its payload.
	`ASSERT_CLK(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "token changed while stalled")

	// Kinds stay within the token classes.
	`ASSERT_IMPLY(a_kind_range, clk, arst_n, m_tvalid, (m_tdata[4:0] <= KIND_MAX), "token kind out of range")

	// No token is empty: string content is sent only when it has bytes.
	`ASSERT_IMPLY(a_len_nonzero, clk, arst_n, m_tvalid, (m_tdata[60:45] != 16'd0), "zero-length token")

	// A two-character comparison always has length two.
	`ASSERT_IMPLY(a_cmp_len, clk, arst_n, (m_tvalid && (m_tdata[4:0] == K_EQ || m_tdata[4:0] == K_NEQ || m_tdata[4:0] == K_LTE || m_tdata[4:0] == K_GTE)), (m_tdata[60:45] == 16'd2), "comparison token length not two")

	// Pad bits above the length stay zero.
	`ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, (m_tdata[63:61] == 3'd0), "tdata pad bits set")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
